// File: src/protobuf_message_field_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the protobuf message field parser.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_MESSAGE_FIELD_PARSER_ASSERT_SVH
`define PROTOBUF_MESSAGE_FIELD_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pbf_pkg.sv
// ----------------------------------------------------------------------------
// pbf_pkg
// Types and constants shared by the protobuf message field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pbf_pkg;

  // Width kept for tag and length varints; higher bits are dropped.
  localparam int LENGTH_BITS = 32;
  // The shift counter must hold the last shift below LENGTH_BITS plus one group of 7.
  localparam int SHIFT_W = $clog2(LENGTH_BITS + 7);

  // Wire types of interest.
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_LEN    = 3'd2;

  // Selected field codes; FLD_NONE marks an unselected string field.
  localparam logic [2:0] FLD_SRC  = 3'd0;
  localparam logic [2:0] FLD_DST  = 3'd1;
  localparam logic [2:0] FLD_NS   = 3'd2;
  localparam logic [2:0] FLD_PAY  = 3'd3;
  localparam logic [2:0] FLD_NONE = 3'd4;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_SKIP,
    PH_LEN,
    PH_DATA,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        is_start;
    logic        is_data;
    logic        is_end;
    logic [1:0]  field_select;
    logic [7:0]  data_out;
    logic [31:0] string_length;
    logic        message_valid;
  } result_t;

endpackage

`default_nettype wire

// File: src/pbf_ifs.sv
// ----------------------------------------------------------------------------
// pbf_in_if / pbf_out_if
// Valid/ready channels for message body bytes and decoded field results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       last_byte;

  modport source (output valid, output body_byte, output last_byte, input ready);
  modport sink   (input valid, input body_byte, input last_byte, output ready);
endinterface

interface pbf_out_if;
  logic        valid;
  logic        ready;
  logic        is_start;
  logic        is_data;
  logic        is_end;
  logic [1:0]  field_select;
  logic [7:0]  data_out;
  logic [31:0] string_length;
  logic        message_valid;

  modport source (output valid, output is_start, output is_data, output is_end,
                  output field_select, output data_out, output string_length,
                  output message_valid, input ready);
  modport sink   (input valid, input is_start, input is_data, input is_end,
                  input field_select, input data_out, input string_length,
                  input message_valid, output ready);
endinterface

`default_nettype wire

// File: src/pbf_core.sv
// ----------------------------------------------------------------------------
// pbf_core
// Parser state and the one-byte decode step of the wire format.
// ----------------------------------------------------------------------------
`default_nettype none

module pbf_core
  import pbf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step_en,
  input  wire item_t   item,
  output logic         has_result,
  output result_t      result
);

  phase_t                  phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0]  acc_r, acc_nxt;
  logic [SHIFT_W-1:0]      shift_r, shift_nxt;
  logic [2:0]              field_r, field_nxt;
  logic [LENGTH_BITS-1:0]  left_r, left_nxt;
  logic                    ns_r, ns_nxt;

  // Varint accumulation for the current byte.
  logic [LENGTH_BITS+6:0]  group_wide;
  logic [LENGTH_BITS-1:0]  acc_take;
  logic [SHIFT_W-1:0]      shift_take;
  logic                    vdone;

  // String start request.
  logic                    bs_en;
  logic                    bs_ended;
  logic [LENGTH_BITS-1:0]  bs_len;
  logic                    bs_has_data;
  logic [LENGTH_BITS-1:0]  len_out;
  logic [LENGTH_BITS+31:0] len_ext;
  logic [LENGTH_BITS-1:0]  left_dec;

  function automatic logic [2:0] map_field(input logic [LENGTH_BITS-4:0] fnum);
    logic [2:0] code;
    code = FLD_NONE;
    if (fnum == (LENGTH_BITS-3)'(2)) code = FLD_SRC;
    if (fnum == (LENGTH_BITS-3)'(3)) code = FLD_DST;
    if (fnum == (LENGTH_BITS-3)'(4)) code = FLD_NS;
    if (fnum == (LENGTH_BITS-3)'(6)) code = FLD_PAY;
    return code;
  endfunction

  always_comb begin
    group_wide = {{LENGTH_BITS{1'b0}}, item.body_byte[6:0]} << shift_r;
    vdone      = !item.body_byte[7];
    if (shift_r < SHIFT_W'(LENGTH_BITS)) begin
      acc_take   = acc_r | group_wide[LENGTH_BITS-1:0];
      shift_take = shift_r + SHIFT_W'(7);
    end else begin
      acc_take   = acc_r;
      shift_take = shift_r;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    shift_nxt = shift_r;
    field_nxt = field_r;
    left_nxt  = left_r;
    ns_nxt    = ns_r;
    bs_en     = 1'b0;
    bs_ended  = 1'b0;
    bs_len    = '0;
    left_dec  = left_r - LENGTH_BITS'(1);
    result    = '0;

    case (phase_r)
      PH_TAG: begin
        acc_nxt   = acc_take;
        shift_nxt = shift_take;
        if (vdone || item.last_byte) begin
          acc_nxt   = '0;
          shift_nxt = '0;
          if (acc_take[2:0] == WT_LEN) begin
            field_nxt = map_field(acc_take[LENGTH_BITS-1:3]);
            if (item.last_byte) begin
              bs_en    = 1'b1;
              bs_ended = 1'b1;
            end else begin
              phase_nxt = PH_LEN;
            end
          end else if (acc_take[2:0] == WT_VARINT) begin
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
      end
      PH_SKIP: begin
        acc_nxt   = acc_take;
        shift_nxt = shift_take;
        if (vdone) begin
          acc_nxt   = '0;
          shift_nxt = '0;
          phase_nxt = PH_TAG;
        end
      end
      PH_LEN: begin
        acc_nxt   = acc_take;
        shift_nxt = shift_take;
        if (vdone || item.last_byte) begin
          acc_nxt   = '0;
          shift_nxt = '0;
          bs_en     = 1'b1;
          bs_ended  = item.last_byte;
          bs_len    = acc_take;
        end
      end
      PH_DATA: begin
        if (field_r != FLD_NONE) begin
          result.is_data      = 1'b1;
          result.field_select = field_r[1:0];
          result.data_out     = item.body_byte;
        end
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_TAG;
        end
      end
      default: begin
      end
    endcase

    // A string that ends with the message is reported as empty.
    bs_has_data = !bs_ended && (bs_len != '0);
    len_out     = bs_ended ? '0 : bs_len;
    if (bs_en) begin
      if (field_nxt != FLD_NONE) begin
        result.is_start     = 1'b1;
        result.field_select = field_nxt[1:0];
        if (field_nxt == FLD_NS) begin
          ns_nxt = bs_has_data;
        end
      end
      if (bs_has_data) begin
        left_nxt  = bs_len;
        phase_nxt = PH_DATA;
      end else begin
        phase_nxt = PH_TAG;
      end
    end
    len_ext = {32'd0, len_out};
    if (result.is_start) begin
      result.string_length = len_ext[31:0];
    end

    result.is_end        = item.last_byte;
    result.message_valid = item.last_byte && ns_nxt;
    has_result = result.is_start || result.is_data || item.last_byte;

    // Every message end returns the parser to its reset state.
    if (item.last_byte) begin
      phase_nxt = PH_TAG;
      acc_nxt   = '0;
      shift_nxt = '0;
      field_nxt = FLD_NONE;
      left_nxt  = '0;
      ns_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      acc_r   <= '0;
      shift_r <= '0;
      field_r <= FLD_NONE;
      left_r  <= '0;
      ns_r    <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      field_r <= field_nxt;
      left_r  <= left_nxt;
      ns_r    <= ns_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/protobuf_message_field_parser.sv
// ----------------------------------------------------------------------------
// protobuf_message_field_parser
// Streaming decoder that extracts selected string fields from a message body.
// ----------------------------------------------------------------------------
// Usage:
// The in_bus channel carries one body byte per transaction, with last_byte
// set on the final byte of a message. The out_bus channel carries at most one
// result transaction per input byte: a start marker (with the declared
// length) or a data byte for string fields 2, 3, 4 and 6, and an end flag
// with message_valid on the final byte. Bytes that produce nothing (tags,
// skipped varints, unselected strings) yield no output transaction.
// A byte is held in the input register, then decoded by the step feeding
// the result register. Throughput is one byte per cycle while the receiver
// keeps out_bus.ready high; the parser state update is the single
// combinational step between the input and result registers.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the tag phase; the same state is restored after every final byte.
// When the receiver stalls, the result register holds its transaction, the
// input register holds one pending byte, and in_bus.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module protobuf_message_field_parser
  import pbf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  pbf_in_if.sink     in_bus,
  pbf_out_if.source  out_bus
);

  // Input register stage.
  logic    in_vld_r;
  item_t   item_r;

  // Result register stage.
  logic    out_vld_r;
  result_t res_r;

  // Decode step outputs.
  logic    has_result;
  result_t result;

  logic    advance;
  logic    step_en;

  // The pipeline moves whenever the result register is free or being drained.
  assign advance      = !out_vld_r || out_bus.ready;
  assign step_en      = in_vld_r && advance;
  assign in_bus.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r.body_byte <= in_bus.body_byte;
      item_r.last_byte <= in_bus.last_byte;
    end
  end

  pbf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .item       (item_r),
    .has_result (has_result),
    .result     (result)
  );

  // Only bytes that report something occupy the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= step_en && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_bus.valid         = out_vld_r;
  assign out_bus.is_start      = res_r.is_start;
  assign out_bus.is_data       = res_r.is_data;
  assign out_bus.is_end        = res_r.is_end;
  assign out_bus.field_select  = res_r.field_select;
  assign out_bus.data_out      = res_r.data_out;
  assign out_bus.string_length = res_r.string_length;
  assign out_bus.message_valid = res_r.message_valid;

endmodule

`default_nettype wire

// File: src/pbf_checker.sv
// ----------------------------------------------------------------------------
// pbf_checker
// Port-level assertions for the protobuf message field parser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "protobuf_message_field_parser_assert.svh"

module pbf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        is_start,
  input wire logic        is_data,
  input wire logic        is_end,
  input wire logic [1:0]  field_select,
  input wire logic [7:0]  data_out,
  input wire logic [31:0] string_length,
  input wire logic        message_valid
);

  logic [45:0] payload;
  assign payload = {is_start, is_data, is_end, field_select, data_out,
                    string_length, message_valid};

  // A stalled result transaction keeps its contents.
  `PBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(payload), "result changed while stalled")

  // Every result transaction reports a start, a data byte or a message end.
  `PBF_ASSERT_NOW(a_out_kind, out_valid, is_start || is_data || is_end, "empty result transaction")

  // A start marker and a data byte never come from the same input byte.
  `PBF_ASSERT_NOW(a_start_data, out_valid, !(is_start && is_data), "start and data together")

  // Data and length fields are zero unless their flag is set.
  `PBF_ASSERT_NOW(a_zero_fields, out_valid, (is_data || data_out == 8'd0) && (is_start || string_length == 32'd0), "stray payload value")

  // The message verdict only appears with the end flag.
  `PBF_ASSERT_NOW(a_valid_end, out_valid && message_valid, is_end, "message_valid without end")

endmodule

bind protobuf_message_field_parser pbf_checker u_pbf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .is_start      (out_bus.is_start),
  .is_data       (out_bus.is_data),
  .is_end        (out_bus.is_end),
  .field_select  (out_bus.field_select),
  .data_out      (out_bus.data_out),
  .string_length (out_bus.string_length),
  .message_valid (out_bus.message_valid)
);

`default_nettype wire

// File: tb/pbf_field_checker.sv
// ----------------------------------------------------------------------------
// pbf_field_checker
// Watches both channels of the field parser, predicts the result of every
// accepted body byte and compares each result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pbf_field_checker
  import pbf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pbf_in_if    in_mon,
  pbf_out_if   out_mon,
  output int   mismatch_count,
  output int   results_pending
);

  // Decoder state, kept in step with the block.
  phase_t      phase;
  logic [31:0] varint_acc;
  int unsigned group_shift;
  logic [2:0]  field_code;
  logic [31:0] string_left;
  logic        ns_nonempty;

  // Results predicted but not yet seen on the output channel, oldest first.
  result_t predicted_events[$];

  task automatic restart_message();
    phase       = PH_TAG;
    varint_acc  = '0;
    group_shift = 0;
    field_code  = FLD_NONE;
    string_left = '0;
    ns_nonempty = 1'b0;
  endtask

  task automatic report(input string what);
    $display("%0t ns: MISMATCH %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [2:0] select_of(input logic [28:0] number);
    case (number)
      29'd2:   return FLD_SRC;
      29'd3:   return FLD_DST;
      29'd4:   return FLD_NS;
      29'd6:   return FLD_PAY;
      default: return FLD_NONE;
    endcase
  endfunction

  // Adds one 7-bit group; bits above the kept width fall off the top.
  task automatic take_group(input logic [7:0] b, output logic complete);
    if (group_shift < LENGTH_BITS) begin
      varint_acc  = varint_acc | (32'(b[6:0]) << group_shift);
      group_shift = group_shift + 7;
    end
    complete = !b[7];
  endtask

  task automatic open_string(input logic [31:0] len, input logic ended, inout result_t r);
    logic has_data;
    has_data = !ended && (len != 0);
    if (field_code != FLD_NONE) begin
      r.is_start      = 1'b1;
      r.field_select  = field_code[1:0];
      r.string_length = ended ? 32'd0 : len;
      if (field_code == FLD_NS)
        ns_nonempty = has_data;
    end
    if (has_data) begin
      string_left = len;
      phase       = PH_DATA;
    end else begin
      phase = PH_TAG;
    end
  endtask

  task automatic decode_body_byte(input logic [7:0] b, input logic final_byte);
    result_t     r;
    logic        complete;
    logic [31:0] value;
    r = '0;
    case (phase)
      PH_TAG: begin
        take_group(b, complete);
        if (complete || final_byte) begin
          value       = varint_acc;
          varint_acc  = '0;
          group_shift = 0;
          if (value[2:0] == WT_LEN) begin
            field_code = select_of(value[31:3]);
            if (final_byte)
              open_string(32'd0, 1'b1, r);
            else
              phase = PH_LEN;
          end else if (value[2:0] == WT_VARINT) begin
            phase = PH_SKIP;
          end else begin
            phase = PH_STOP;
          end
        end
      end
      PH_SKIP: begin
        take_group(b, complete);
        if (complete) begin
          varint_acc  = '0;
          group_shift = 0;
          phase       = PH_TAG;
        end
      end
      PH_LEN: begin
        take_group(b, complete);
        if (complete || final_byte) begin
          value       = varint_acc;
          varint_acc  = '0;
          group_shift = 0;
          open_string(value, final_byte, r);
        end
      end
      PH_DATA: begin
        if (field_code != FLD_NONE) begin
          r.is_data      = 1'b1;
          r.field_select = field_code[1:0];
          r.data_out     = b;
        end
        string_left = string_left - 1;
        if (string_left == 0)
          phase = PH_TAG;
      end
      default: ;
    endcase
    if (r.is_start || r.is_data || final_byte) begin
      r.is_end        = final_byte;
      r.message_valid = final_byte && ns_nonempty;
      predicted_events = {predicted_events, r};
    end
    if (final_byte)
      restart_message();
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got %0h, predicted %0h", name, got, want));
  endtask

  task automatic compare_result();
    result_t want;
    if (predicted_events.size() == 0) begin
      report("result transaction with no prediction pending");
      return;
    end
    want = predicted_events.pop_front();
    check_field("is_start", 32'(out_mon.is_start), 32'(want.is_start));
    check_field("is_data", 32'(out_mon.is_data), 32'(want.is_data));
    check_field("is_end", 32'(out_mon.is_end), 32'(want.is_end));
    check_field("field_select", 32'(out_mon.field_select), 32'(want.field_select));
    check_field("data_out", 32'(out_mon.data_out), 32'(want.data_out));
    check_field("string_length", out_mon.string_length, want.string_length);
    check_field("message_valid", 32'(out_mon.message_valid), 32'(want.message_valid));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_message();
      predicted_events.delete();
      mismatch_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        decode_body_byte(in_mon.body_byte, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready)
        compare_result();
    end
    results_pending <= predicted_events.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds protobuf message bodies through the field parser: a short directed
// set of corner cases, then randomly built messages, with random idling on
// both channels. A checker module beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pbf_pkg::*;

  // Protobuf field numbers that the parser selects.
  localparam int NUM_SRC = 2;
  localparam int NUM_DST = 3;
  localparam int NUM_NS  = 4;
  localparam int NUM_PAY = 6;

  // Wire types the parser does not understand; any of them stops parsing.
  localparam logic [2:0] WT_I64    = 3'd1;
  localparam logic [2:0] WT_SGROUP = 3'd3;
  localparam logic [2:0] WT_EGROUP = 3'd4;
  localparam logic [2:0] WT_I32    = 3'd5;
  localparam logic [2:0] WT_RSV6   = 3'd6;
  localparam logic [2:0] WT_RSV7   = 3'd7;

  localparam int RANDOM_BYTES      = 1250;
  localparam int LONG_STALL_CYCLES = 80;
  // The block holds at most two transactions in flight, one in each register;
  // this margin is plenty to see any stray output.
  localparam int DRAIN_CYCLES      = 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Shared knobs between the stimulus and the receiver process.
  logic idle_on       = 1'b1;
  logic stall_request = 1'b0;

  int mismatch_count;
  int results_pending;
  int bytes_sent;
  int msg_index;

  // Body of the message currently being built.
  logic [7:0] msg_q[$];

  pbf_in_if  in_bus ();
  pbf_out_if out_bus ();

  protobuf_message_field_parser dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus.sink),
    .out_bus (out_bus.source)
  );

  pbf_field_checker field_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Safety net: a correct run finishes far earlier than this, even with
  // every byte taking the longest sender gap and every result the longest
  // receiver stall.
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // ---------------------------------------------------------------------------
  // Message construction helpers. Everything is appended to msg_q.
  // ---------------------------------------------------------------------------

  task automatic append_byte(input logic [7:0] b);
    msg_q = {msg_q, b};
  endtask

  // Base-128 varint, least significant group first, MSB set on all but the
  // final group.
  task automatic put_varint(input logic [63:0] value);
    logic [63:0] rest;
    logic        more;
    rest = value;
    do begin
      more = (rest >> 7) != 0;
      append_byte({more, rest[6:0]});
      rest = rest >> 7;
    end while (more);
  endtask

  task automatic put_tag(input logic [31:0] number, input logic [2:0] wire_type);
    put_varint((64'(number) << 3) | 64'(wire_type));
  endtask

  task automatic put_bytes(input int count);
    repeat (count) append_byte(8'($urandom));
  endtask

  task automatic put_string_field(input int number, input int len);
    put_tag(number, WT_LEN);
    put_varint(64'(len));
    put_bytes(len);
  endtask

  function automatic int selected_num();
    case ($urandom_range(0, 3))
      0:       return NUM_SRC;
      1:       return NUM_DST;
      2:       return NUM_NS;
      default: return NUM_PAY;
    endcase
  endfunction

  // Field numbers the parser must skip, including very large ones whose tag
  // fills most of the 32 kept bits.
  function automatic int unselected_num();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 1;
      2:       return 5;
      3:       return 7;
      default: return $urandom_range(8, 2 ** 29 - 1);
    endcase
  endfunction

  function automatic logic [2:0] other_wire_type();
    case ($urandom_range(0, 5))
      0:       return WT_I64;
      1:       return WT_SGROUP;
      2:       return WT_EGROUP;
      3:       return WT_I32;
      4:       return WT_RSV6;
      default: return WT_RSV7;
    endcase
  endfunction

  // Strings are mostly short so that many fields fit in the run.
  function automatic int string_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(0, 6);
    return $urandom_range(7, 60);
  endfunction

  // Builds one random message. Most are well-formed runs of fields with
  // random content; some are cut at a random byte, and a few are noise.
  task automatic build_random_message();
    int n_fields;
    int kind;
    int len;
    int cut;
    int f;
    msg_q.delete();
    if ($urandom_range(0, 99) < 8) begin
      put_bytes($urandom_range(1, 12));
      return;
    end
    n_fields = $urandom_range(1, 4);
    for (f = 0; f < n_fields; f++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        put_string_field(selected_num(), string_len());
      end else if (kind < 57) begin
        put_string_field(unselected_num(), string_len());
      end else if (kind < 75) begin
        put_tag($urandom_range(0, 20), WT_VARINT);
        put_varint({$urandom, $urandom} >> $urandom_range(0, 63));
      end else if (kind < 82) begin
        put_string_field(selected_num(), 0);
      end else if (kind < 87) begin
        // Tag and length carry junk above the 32 kept bits, so the varints
        // run to five bytes or more and the decoder must drop the excess.
        len = string_len();
        put_varint({$urandom, (32'(selected_num()) << 3) | 32'(WT_LEN)});
        put_varint({$urandom, 32'(len)});
        put_bytes(len);
      end else if (kind < 91) begin
        // A huge declared length; the message ends inside the string.
        put_tag(selected_num(), WT_LEN);
        put_varint(64'($urandom));
        put_bytes($urandom_range(1, 4));
        break;
      end else begin
        put_tag($urandom_range(0, 40), other_wire_type());
        put_bytes($urandom_range(0, 3));
      end
    end
    // Cutting the message exercises every phase being interrupted by the
    // final byte: tag, length, skipped varint and string data.
    if (msg_q.size() > 1 && $urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, msg_q.size() - 1);
      while (msg_q.size() > cut)
        void'(msg_q.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input channel driver.
  // ---------------------------------------------------------------------------

  // Offers one byte and returns in the time step of the edge at which the
  // transaction was accepted. valid is left high; the next call either
  // replaces the data or drops valid for a gap, in that same step.
  task automatic send_byte(input logic [7:0] b, input logic final_byte);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.body_byte <= b;
    in_bus.last_byte <= final_byte;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic send_message();
    foreach (msg_q[i])
      send_byte(msg_q[i], i == msg_q.size() - 1);
    bytes_sent += msg_q.size();
  endtask

  // Stops offering and waits until every predicted result has come out.
  // The first edge lets the checker publish the count for the transaction
  // that was accepted in this very time step.
  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, and one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_request) begin
        // With the output held back, the block's two registers fill and it
        // has to push back on the input while the sender keeps offering.
        out_bus.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        stall_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and verdict.
  // ---------------------------------------------------------------------------
  initial begin
    in_bus.valid     <= 1'b0;
    in_bus.body_byte <= '0;
    in_bus.last_byte <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A one-byte message: tag with wire type varint, cut by
    // the end of the message, so only the end flag comes out.
    msg_q.delete();
    put_tag(0, WT_VARINT);
    send_message();

    // Namespace string whose only byte is also the final byte: data and end
    // arrive in one transaction, and the message is valid.
    msg_q.delete();
    put_tag(NUM_NS, WT_LEN);
    put_varint(64'(1));
    append_byte(8'hFF);
    send_message();

    // An empty source id, then a destination tag cut by the end, which
    // replaces that field with an empty string.
    msg_q.delete();
    put_string_field(NUM_SRC, 0);
    put_tag(NUM_DST, WT_LEN);
    send_message();

    // Unknown wire type: the rest of the message is ignored.
    msg_q.delete();
    put_tag(1, WT_I64);
    append_byte(8'h55);
    append_byte(8'hAA);
    send_message();

    // Skipped varint, an unselected string, then a payload cut short.
    msg_q.delete();
    put_tag(1, WT_VARINT);
    put_varint(64'(150));
    put_tag(5, WT_LEN);
    put_varint(64'(2));
    append_byte(8'h00);
    append_byte(8'h80);
    put_tag(NUM_PAY, WT_LEN);
    put_varint(64'(3));
    append_byte(8'h01);
    send_message();

    // Namespace length varint left unfinished by the end of the message.
    msg_q.delete();
    put_tag(NUM_NS, WT_LEN);
    append_byte(8'h85);
    send_message();

    // Unselected string tag cut by the end: no start, only the end flag.
    msg_q.delete();
    put_tag(1, WT_LEN);
    send_message();

    // Random part. Some messages run without any idling on either side; one
    // early on meets a long receiver hold-off, and twice the sender pauses
    // until everything has drained.
    bytes_sent = 0;
    msg_index  = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      idle_on = ($urandom_range(0, 7) != 0);
      if (msg_index == 25) begin
        idle_on       = 1'b0;
        stall_request = 1'b1;
      end
      if (msg_index == 15 || msg_index == 45)
        wait_for_drain();
      build_random_message();
      send_message();
      msg_index++;
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
